// File: hw/rtl/dfslfo_pkg.sv
package dfslfo_pkg;

   localparam int SINE_ENTRIES  = 256;
   localparam int FRACTION_BITS = 8;
   localparam int IDX_W         = $clog2(SINE_ENTRIES);
   localparam int QUARTER       = SINE_ENTRIES / 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int OP_W       = 2;
   localparam int DELTA_W    = 16;
   localparam int LEVEL_W    = 8;
   localparam int ACCUM_W    = 32;
   localparam int WHOLE_W    = ACCUM_W - FRACTION_BITS;
   localparam int RATE_W     = 17;
   localparam int DIV_CNT_W  = 5;
   localparam int PC_W       = 4;

   localparam logic [RATE_W-1:0]    RATE_RESET = RATE_W'(32'h10000);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS  = DIV_CNT_W'(RATE_W);

   // Operation codes of an input word
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRE_DELAY    = 3'd0,
      CSR_ATTACK_LEN   = 3'd1,
      CSR_PERIOD       = 3'd2,
      CSR_PHASE_OFFSET = 3'd3,
      CSR_PHASE_CAP    = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      STAGE_DISABLED  = 2'd0,
      STAGE_PRE_DELAY = 2'd1,
      STAGE_ATTACK    = 2'd2,
      STAGE_SUSTAIN   = 2'd3
   } stage_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_ACCEPT,
      UOP_DECODE,
      UOP_PRE_CHECK,
      UOP_MUL_PHASE,
      UOP_LOOKUP,
      UOP_ATT_LOAD,
      UOP_DIV_STEP,
      UOP_ATT_DONE,
      UOP_UNSCALED,
      UOP_EMIT,
      UOP_RATE_LOAD,
      UOP_RATE_DONE
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_RATE_DIRTY,
      COND_NO_ITEM,
      COND_NOT_ACTIVE_TICK,
      COND_STAGE_PRE,
      COND_NO_SCALE,
      COND_DIV_MORE,
      COND_OUT_FREE
   } cond_type;

   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type STEP_IDLE      = 4'd0;
   localparam pc_type STEP_ACCEPT    = 4'd1;
   localparam pc_type STEP_DECODE    = 4'd2;
   localparam pc_type STEP_PRE       = 4'd3;
   localparam pc_type STEP_MUL       = 4'd4;
   localparam pc_type STEP_LOOKUP    = 4'd5;
   localparam pc_type STEP_ATT_LOAD  = 4'd6;
   localparam pc_type STEP_ATT_DIV   = 4'd7;
   localparam pc_type STEP_ATT_DONE  = 4'd8;
   localparam pc_type STEP_UNSCALED  = 4'd9;
   localparam pc_type STEP_EMIT      = 4'd10;
   localparam pc_type STEP_EMIT_WAIT = 4'd11;
   localparam pc_type STEP_RATE      = 4'd12;
   localparam pc_type STEP_RATE_DIV  = 4'd13;
   localparam pc_type STEP_RATE_DONE = 4'd14;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      pc_type   target;
   } uword_type;

   typedef struct packed {
      uop_type uop;
      logic    ready;
      logic    accept;
      logic    emit;
   } ctrl_type;

   typedef struct packed {
      logic active_tick;
      logic stage_pre;
      logic no_scale;
      logic div_more;
   } dp_flags_type;

   typedef struct packed {
      logic         rate_dirty;
      logic         item_valid;
      logic         out_free;
      dp_flags_type dp;
   } seq_status_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] pre_delay;
      logic [CSR_DATA_W-1:0] attack_len;
      logic [CSR_DATA_W-1:0] period;
      logic [CSR_DATA_W-1:0] phase_offset;
      logic [CSR_DATA_W-1:0] phase_cap;
   } cfg_type;

   // round(256 * sin(k * pi / 128)) for k = 0..64
   localparam logic [8:0] QUARTER_WAVE [0:QUARTER] = '{
        9'd0,   9'd6,  9'd13,  9'd19,  9'd25,  9'd31,  9'd38,  9'd44,
       9'd50,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
       9'd98, 9'd104, 9'd109, 9'd115, 9'd121, 9'd126, 9'd132, 9'd137,
      9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd172, 9'd177,
      9'd181, 9'd185, 9'd190, 9'd194, 9'd198, 9'd202, 9'd206, 9'd209,
      9'd213, 9'd216, 9'd220, 9'd223, 9'd226, 9'd229, 9'd231, 9'd234,
      9'd237, 9'd239, 9'd241, 9'd243, 9'd245, 9'd247, 9'd248, 9'd250,
      9'd251, 9'd252, 9'd253, 9'd254, 9'd255, 9'd255, 9'd256, 9'd256,
      9'd256
   };

   // Sine entry halved (floor) and clamped to -128..127, as two's complement bits
   function automatic logic [LEVEL_W-1:0] sine_half(input logic [IDX_W-1:0] idx);
      logic [6:0]         k;
      logic [8:0]         v;
      logic [9:0]         rounded;
      logic [LEVEL_W-1:0] mag;
      if (idx[6]) begin
         k = 7'd64 - {1'b0, idx[5:0]};
      end else begin
         k = {1'b0, idx[5:0]};
      end
      v = QUARTER_WAVE[k];
      if (!idx[7]) begin
         mag = (v[8:1] > 8'd127) ? 8'd127 : v[8:1];
         sine_half = mag;
      end else begin
         rounded = 10'(v) + 10'd1;
         mag = rounded[8:1];
         sine_half = LEVEL_W'(8'd0 - mag);
      end
   endfunction

   // Control store: one word per step
   function automatic uword_type ucode_rom(input pc_type pc);
      case (pc)
         STEP_IDLE:      ucode_rom = '{UOP_NOP,       COND_RATE_DIRTY,      STEP_RATE};
         STEP_ACCEPT:    ucode_rom = '{UOP_ACCEPT,    COND_NO_ITEM,         STEP_IDLE};
         STEP_DECODE:    ucode_rom = '{UOP_DECODE,    COND_NOT_ACTIVE_TICK, STEP_EMIT};
         STEP_PRE:       ucode_rom = '{UOP_PRE_CHECK, COND_STAGE_PRE,       STEP_EMIT};
         STEP_MUL:       ucode_rom = '{UOP_MUL_PHASE, COND_NEVER,           STEP_IDLE};
         STEP_LOOKUP:    ucode_rom = '{UOP_LOOKUP,    COND_NO_SCALE,        STEP_UNSCALED};
         STEP_ATT_LOAD:  ucode_rom = '{UOP_ATT_LOAD,  COND_NEVER,           STEP_IDLE};
         STEP_ATT_DIV:   ucode_rom = '{UOP_DIV_STEP,  COND_DIV_MORE,        STEP_ATT_DIV};
         STEP_ATT_DONE:  ucode_rom = '{UOP_ATT_DONE,  COND_ALWAYS,          STEP_EMIT};
         STEP_UNSCALED:  ucode_rom = '{UOP_UNSCALED,  COND_NEVER,           STEP_IDLE};
         STEP_EMIT:      ucode_rom = '{UOP_EMIT,      COND_OUT_FREE,        STEP_IDLE};
         STEP_EMIT_WAIT: ucode_rom = '{UOP_NOP,       COND_ALWAYS,          STEP_EMIT};
         STEP_RATE:      ucode_rom = '{UOP_RATE_LOAD, COND_NEVER,           STEP_IDLE};
         STEP_RATE_DIV:  ucode_rom = '{UOP_DIV_STEP,  COND_DIV_MORE,        STEP_RATE_DIV};
         STEP_RATE_DONE: ucode_rom = '{UOP_RATE_DONE, COND_ALWAYS,          STEP_IDLE};
         default:        ucode_rom = '{UOP_NOP,       COND_ALWAYS,          STEP_IDLE};
      endcase
   endfunction

endpackage

// File: hw/rtl/dfslfo_seq.sv
module dfslfo_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  dfslfo_pkg::seq_status_type status,
   output dfslfo_pkg::ctrl_type       ctrl
);
   import dfslfo_pkg::*;

   pc_type    pc_ff;
   pc_type    pc_in;
   uword_type uword;
   logic      cond_hit;
   logic      can_take;

   assign uword    = ucode_rom(pc_ff);
   assign can_take = !status.rate_dirty;

   always_comb begin
      ctrl.uop    = uword.uop;
      ctrl.ready  = (uword.uop == UOP_ACCEPT) && can_take;
      ctrl.accept = ctrl.ready && status.item_valid;
      ctrl.emit   = (uword.uop == UOP_EMIT) && status.out_free;
   end

   always_comb begin
      unique case (uword.cond)
         COND_NEVER:           cond_hit = 1'b0;
         COND_ALWAYS:          cond_hit = 1'b1;
         COND_RATE_DIRTY:      cond_hit = status.rate_dirty;
         COND_NO_ITEM:         cond_hit = !(can_take && status.item_valid);
         COND_NOT_ACTIVE_TICK: cond_hit = !status.dp.active_tick;
         COND_STAGE_PRE:       cond_hit = status.dp.stage_pre;
         COND_NO_SCALE:        cond_hit = status.dp.no_scale;
         COND_DIV_MORE:        cond_hit = status.dp.div_more;
         COND_OUT_FREE:        cond_hit = status.out_free;
         default:              cond_hit = 1'b0;
      endcase
      pc_in = cond_hit ? uword.target : pc_type'(pc_ff + pc_type'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: hw/rtl/dfslfo_dp.sv
module dfslfo_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  dfslfo_pkg::ctrl_type                ctrl,
   input  dfslfo_pkg::cfg_type                 cfg,
   input  logic [dfslfo_pkg::OP_W-1:0]         req_op,
   input  logic [dfslfo_pkg::DELTA_W-1:0]      req_delta,
   output dfslfo_pkg::dp_flags_type            flags,
   output logic [dfslfo_pkg::LEVEL_W-1:0]      level
);
   import dfslfo_pkg::*;

   // Architectural state
   stage_type             stage_ff,  stage_in;
   logic [ACCUM_W-1:0]    accum_ff,  accum_in;
   logic [RATE_W-1:0]     rate_ff,   rate_in;
   logic [LEVEL_W-1:0]    level_ff,  level_in;

   // Item and scratch registers
   logic [OP_W-1:0]       op_ff,     op_in;
   logic [DELTA_W-1:0]    delta_ff,  delta_in;
   logic [ACCUM_W-1:0]    prod_ff,   prod_in;
   logic [LEVEL_W-1:0]    res_ff,    res_in;
   logic                  neg_ff,    neg_in;

   // Shared restoring divider: num_ff holds dividend, then quotient
   logic [RATE_W-1:0]     num_ff,    num_in;
   logic [7:0]            rem_ff,    rem_in;
   logic [7:0]            den_ff,    den_in;
   logic [DIV_CNT_W-1:0]  cnt_ff,    cnt_in;

   logic [WHOLE_W-1:0]    whole;
   logic [40:0]           mul_full;
   logic [7:0]            pos_lo;
   logic                  pos_hi;
   logic [7:0]            capped;
   logic [IDX_W-1:0]      sine_idx;
   logic [LEVEL_W-1:0]    res_mag;
   logic [15:0]           att_prod;
   logic [8:0]            trial;
   logic                  trial_ge;
   logic [8:0]            trial_sub;

   assign whole    = accum_ff[ACCUM_W-1:FRACTION_BITS];
   assign mul_full = 41'(whole) * 41'(rate_ff);

   // Phase is prod >> 8 sign-extended; any upper bit set exceeds the cap
   assign pos_hi   = (prod_ff[ACCUM_W-1:16] != '0);
   assign pos_lo   = prod_ff[15:FRACTION_BITS];
   assign capped   = ((cfg.phase_cap != '0) && (pos_hi || (pos_lo > cfg.phase_cap)))
                     ? cfg.phase_cap : pos_lo;
   assign sine_idx = IDX_W'(capped + cfg.phase_offset);

   assign res_mag  = res_ff[LEVEL_W-1] ? LEVEL_W'(8'd0 - res_ff) : res_ff;
   assign att_prod = 16'(res_mag) * 16'(whole[7:0]);

   assign trial     = {rem_ff, num_ff[RATE_W-1]};
   assign trial_ge  = (trial >= {1'b0, den_ff});
   assign trial_sub = trial - {1'b0, den_ff};

   assign flags.active_tick = (op_ff == OP_TICK) && (stage_ff != STAGE_DISABLED);
   assign flags.stage_pre   = (stage_ff == STAGE_PRE_DELAY);
   assign flags.no_scale    = (stage_ff != STAGE_ATTACK) || (whole >= WHOLE_W'(cfg.attack_len));
   assign flags.div_more    = (cnt_ff != DIV_CNT_W'(1));

   assign level = level_ff;

   always_comb begin
      stage_in = stage_ff;
      accum_in = accum_ff;
      rate_in  = rate_ff;
      level_in = level_ff;
      op_in    = op_ff;
      delta_in = delta_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      neg_in   = neg_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;

      if (ctrl.accept) begin
         op_in    = req_op;
         delta_in = req_delta;
      end

      unique case (ctrl.uop)
         UOP_DECODE: begin
            case (op_ff)
               OP_TICK: begin
                  if (stage_ff == STAGE_DISABLED) begin
                     level_in = '0;
                  end else begin
                     accum_in = accum_ff + ACCUM_W'(delta_ff);
                  end
               end
               OP_START: begin
                  stage_in = STAGE_PRE_DELAY;
                  accum_in = '0;
                  level_in = '0;
               end
               OP_STOP: begin
                  stage_in = STAGE_DISABLED;
                  accum_in = '0;
                  level_in = '0;
               end
               default: ;
            endcase
         end
         UOP_PRE_CHECK: begin
            if (stage_ff == STAGE_PRE_DELAY) begin
               level_in = '0;
               if (whole >= WHOLE_W'(cfg.pre_delay)) begin
                  accum_in = '0;
                  stage_in = STAGE_ATTACK;
               end
            end
         end
         UOP_MUL_PHASE: begin
            prod_in = mul_full[ACCUM_W-1:0];
         end
         UOP_LOOKUP: begin
            res_in = sine_half(sine_idx);
         end
         UOP_ATT_LOAD: begin
            num_in = RATE_W'(att_prod);
            den_in = cfg.attack_len;
            rem_in = '0;
            cnt_in = DIV_STEPS;
            neg_in = res_ff[LEVEL_W-1];
         end
         UOP_DIV_STEP: begin
            rem_in = trial_ge ? trial_sub[7:0] : trial[7:0];
            num_in = {num_ff[RATE_W-2:0], trial_ge};
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
         UOP_ATT_DONE: begin
            level_in = neg_ff ? LEVEL_W'(8'd0 - num_ff[7:0]) : num_ff[7:0];
         end
         UOP_UNSCALED: begin
            level_in = res_ff;
            if (stage_ff == STAGE_ATTACK) begin
               stage_in = STAGE_SUSTAIN;
            end
         end
         UOP_RATE_LOAD: begin
            num_in = RATE_RESET;
            den_in = (cfg.period == '0) ? 8'd1 : cfg.period;
            rem_in = '0;
            cnt_in = DIV_STEPS;
         end
         UOP_RATE_DONE: begin
            rate_in = num_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STAGE_DISABLED;
         accum_ff <= '0;
         rate_ff  <= RATE_RESET;
         level_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         stage_ff <= stage_in;
         accum_ff <= accum_in;
         rate_ff  <= rate_in;
         level_ff <= level_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      delta_ff <= delta_in;
      prod_ff  <= prod_in;
      res_ff   <= res_in;
      neg_ff   <= neg_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   a_div_count_live: assert property (@(posedge clock) disable iff (reset)
      (ctrl.uop == UOP_DIV_STEP) |-> (cnt_ff != '0))
      else $error("divider stepped with an exhausted count");

   a_att_quotient_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.uop == UOP_ATT_DONE) |-> (num_ff <= RATE_W'(128)))
      else $error("attack quotient out of level range");

   a_att_scale_only_in_attack: assert property (@(posedge clock) disable iff (reset)
      (ctrl.uop == UOP_ATT_LOAD) |->
         ((stage_ff == STAGE_ATTACK) && (whole < WHOLE_W'(cfg.attack_len))))
      else $error("attack scaling entered outside the fade-in");

endmodule

// File: hw/rtl/delayed_fade_in_sine_lfo_top.sv
// Sine LFO with pre-delay and linear fade-in. Each request word carries an op (tick, start,
// stop) and an 8.8 tick delta, and produces exactly one response word holding the signed
// 8-bit level after that op. A small control store steps a shared datapath: one 24x17
// multiplier for the phase, a sine lookup, an 8x8 multiplier and a 17-step restoring
// divider used both for the fade-in scale and for the rate 65536/period. Path of a request
// word: start, stop, unused ops and ticks while disabled go from decode straight to the
// response; a pre-delay tick adds the pre-delay check; a sustain tick (or the tick that ends
// the fade-in) also runs the phase multiply and the sine lookup; a tick during the fade-in
// adds the 8x8 multiply and the divider. Writing period launches the same divider to
// recompute the rate; requests are held off (req_ready low) until it is done. The
// response sits in an output register, so the next request is taken while it waits.
module delayed_fade_in_sine_lfo_top (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dfslfo_pkg::OP_W-1:0]            req_op,
   input  logic [dfslfo_pkg::DELTA_W-1:0]         req_delta,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dfslfo_pkg::LEVEL_W-1:0]  rsp_level,

   input  logic                                   csr_write_en,
   input  logic [dfslfo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dfslfo_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import dfslfo_pkg::*;

   cfg_type            cfg_ff,        cfg_in;
   logic               rate_dirty_ff, rate_dirty_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff,  rsp_level_in;

   ctrl_type           ctrl;
   seq_status_type     status;
   dp_flags_type       dp_flags;
   logic [LEVEL_W-1:0] dp_level;
   logic               period_write;

   assign period_write = csr_write_en && (csr_idx_type'(csr_index) == CSR_PERIOD);

   // Register file: plain writes, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PRE_DELAY:    cfg_in.pre_delay    = csr_wdata;
            CSR_ATTACK_LEN:   cfg_in.attack_len   = csr_wdata;
            CSR_PERIOD:       cfg_in.period       = csr_wdata;
            CSR_PHASE_OFFSET: cfg_in.phase_offset = csr_wdata;
            CSR_PHASE_CAP:    cfg_in.phase_cap    = csr_wdata;
            default: ;
         endcase
      end
   end

   // Rate needs recomputing after a period write; a fresh write wins over the clear
   always_comb begin
      rate_dirty_in = rate_dirty_ff;
      if (ctrl.uop == UOP_RATE_LOAD) begin
         rate_dirty_in = 1'b0;
      end
      if (period_write) begin
         rate_dirty_in = 1'b1;
      end
   end

   // Response register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = dp_level;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pre_delay    <= '0;
         cfg_ff.attack_len   <= '0;
         cfg_ff.period       <= CSR_DATA_W'(1);
         cfg_ff.phase_offset <= '0;
         cfg_ff.phase_cap    <= '0;
         rate_dirty_ff       <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         rate_dirty_ff <= rate_dirty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
   end

   // A period write in this very cycle also holds off acceptance
   assign status.rate_dirty = rate_dirty_ff || period_write;
   assign status.item_valid = req_valid;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.dp         = dp_flags;

   dfslfo_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   dfslfo_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .cfg       (cfg_ff),
      .req_op    (req_op),
      .req_delta (req_delta),
      .flags     (dp_flags),
      .level     (dp_level)
   );

   assign req_ready = ctrl.ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

   a_no_accept_with_stale_rate: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !rate_dirty_ff)
      else $error("request word accepted before the rate was recomputed");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response word overwritten before it was taken");

endmodule

// File: sim/tb_delayed_fade_in_sine_lfo_top.sv
module tb_delayed_fade_in_sine_lfo_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dfslfo_pkg::*;

   // Op code the block must ignore (it still answers with the held level)
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int  CYCLE_LIMIT  = 300000;
   localparam int  DRAIN_CYCLES = 40;
   localparam int  HOLD_CYCLES  = 400;
   localparam real TWO_PI       = 6.283185307179586;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [DELTA_W-1:0] delta;
   } lfo_word_type;

   typedef struct packed {
      logic [31:0]        seq;
      logic [OP_W-1:0]    op;
      logic [LEVEL_W-1:0] level;
   } level_expect_type;

   logic clock;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [OP_W-1:0]                    req_op = '0;
   logic [DELTA_W-1:0]                 req_delta = '0;

   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [LEVEL_W-1:0]          rsp_level;

   logic                               csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]               csr_index = '0;
   logic [CSR_DATA_W-1:0]              csr_wdata = '0;

   delayed_fade_in_sine_lfo_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_delta    (req_delta),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_level    (rsp_level),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Oscillator predictor: own copy of the settings and of the state
   // ------------------------------------------------------------------
   logic [7:0]          cfg_pre_delay;
   logic [7:0]          cfg_attack;
   logic [7:0]          cfg_period;
   logic [7:0]          cfg_offset;
   logic [7:0]          cfg_cap;

   stage_type           lfo_stage;
   logic [ACCUM_W-1:0]  lfo_accum;
   logic [RATE_W-1:0]   lfo_rate;
   logic [LEVEL_W-1:0]  lfo_level;

   int                  sine_tab [SINE_ENTRIES];

   lfo_word_type        word_q [$];        // words waiting for the driver
   level_expect_type    level_expect_q [$]; // levels owed by the block

   int                  errors = 0;
   int                  cycles = 0;
   int                  words_sent = 0;
   bit                  idle_on = 1'b1;

   function automatic void lfo_reset();
      cfg_pre_delay = '0;
      cfg_attack    = '0;
      cfg_period    = 8'd1;
      cfg_offset    = '0;
      cfg_cap       = '0;
      lfo_stage     = STAGE_DISABLED;
      lfo_accum     = '0;
      lfo_rate      = RATE_RESET;
      lfo_level     = '0;
   endfunction

   // Advance the oscillator by one word and return the level it leaves behind
   function automatic logic [LEVEL_W-1:0] lfo_level_after(input logic [OP_W-1:0] op,
                                                          input logic [DELTA_W-1:0] delta);
      logic [WHOLE_W-1:0] whole;
      logic [31:0]        prod;
      logic [31:0]        pos;
      int                 amp;
      case (op)
         OP_TICK: begin
            case (lfo_stage)
               STAGE_PRE_DELAY: begin
                  lfo_accum = lfo_accum + ACCUM_W'(delta);
                  lfo_level = '0;
                  if ((lfo_accum >> FRACTION_BITS) >= 32'(cfg_pre_delay)) begin
                     lfo_accum = '0;
                     lfo_stage = STAGE_ATTACK;
                  end
               end
               STAGE_ATTACK, STAGE_SUSTAIN: begin
                  lfo_accum = lfo_accum + ACCUM_W'(delta);
                  whole = lfo_accum[ACCUM_W-1:FRACTION_BITS];
                  // truncate to 32 bits, then shift right keeping the sign
                  prod = 32'(whole) * 32'(lfo_rate);
                  pos  = {{FRACTION_BITS{prod[31]}}, prod[31:FRACTION_BITS]};
                  if (cfg_cap != 0 && pos > 32'(cfg_cap)) begin
                     pos = 32'(cfg_cap);
                  end
                  pos = pos + 32'(cfg_offset);
                  amp = sine_tab[pos[IDX_W-1:0]];
                  // halve rounding toward minus infinity, then clamp
                  if (amp >= 0) begin
                     amp = amp / 2;
                  end else begin
                     amp = -((-amp + 1) / 2);
                  end
                  if (amp > 127) amp = 127;
                  if (amp < -128) amp = -128;
                  if (lfo_stage == STAGE_ATTACK) begin
                     if (32'(whole) < 32'(cfg_attack)) begin
                        amp = (amp * int'(whole)) / int'(cfg_attack);
                     end else begin
                        lfo_stage = STAGE_SUSTAIN;
                     end
                  end
                  lfo_level = LEVEL_W'(amp);
               end
               default: lfo_level = '0;
            endcase
         end
         OP_START: begin
            lfo_stage = STAGE_PRE_DELAY;
            lfo_accum = '0;
            lfo_level = '0;
         end
         OP_STOP: begin
            lfo_stage = STAGE_DISABLED;
            lfo_accum = '0;
            lfo_level = '0;
         end
         default: ; // unused op: hold everything
      endcase
      return lfo_level;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   // Mostly short gaps, a few long ones; none at all while idling is off
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // Clock, cycle limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request driver: predict on acceptance, then offer the next word
   // ------------------------------------------------------------------
   bit               offering = 1'b0;
   int               send_gap = 0;
   lfo_word_type     drv_word;
   level_expect_type drv_expect;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            drv_expect.seq   = words_sent;
            drv_expect.op    = req_op;
            drv_expect.level = lfo_level_after(req_op, req_delta);
            level_expect_q.push_back(drv_expect);
            words_sent++;
            offering = 1'b0;
            send_gap = pick_gap();
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (word_q.size() > 0) begin
               drv_word = word_q.pop_front();
               req_op    <= drv_word.op;
               req_delta <= drv_word.delta;
               offering  = 1'b1;
            end
         end
         // one assignment per edge keeps valid steady across back-to-back words
         req_valid <= offering;
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: compare each word with the oldest expectation
   // ------------------------------------------------------------------
   int               take_gap = 0;
   int               hold_left = 0;
   bit               held_once = 1'b0;
   int               rsp_count = 0;
   bit               ready_next;
   level_expect_type mon_expect;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (level_expect_q.size() == 0) begin
               report_mismatch($sformatf("level %0d with no word outstanding",
                                         rsp_level));
            end else begin
               mon_expect = level_expect_q.pop_front();
               if (rsp_level !== mon_expect.level) begin
                  report_mismatch($sformatf("word %0d op %0d: level %0d, expected %0d",
                                            mon_expect.seq, mon_expect.op, rsp_level,
                                            $signed(mon_expect.level)));
               end
            end
            // Back-pressure once for a long stretch while the sender keeps offering,
            // so the output register fills and the block stalls its input.
            if (!held_once && rsp_count >= 100 && word_q.size() > 10) begin
               held_once = 1'b1;
               hold_left = HOLD_CYCLES;
            end else begin
               take_gap = pick_gap();
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_word(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] delta);
      lfo_word_type w;
      w.op    = op;
      w.delta = delta;
      word_q.push_back(w);
   endtask

   // Mostly small deltas so pre-delay and fade-in are walked through tick by tick
   function automatic logic [DELTA_W-1:0] pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return DELTA_W'($urandom_range(0, 16'h03ff));
      if (r < 80) return DELTA_W'($urandom_range(0, 16'h3fff));
      return DELTA_W'($urandom_range(0, 16'hffff));
   endfunction

   // Drain: wait for every owed level, then let the block settle
   task automatic wait_drained();
      while (word_q.size() != 0 || offering || level_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         CSR_PRE_DELAY:    cfg_pre_delay = val;
         CSR_ATTACK_LEN:   cfg_attack    = val;
         CSR_PERIOD: begin
            cfg_period = val;
            lfo_rate   = RATE_W'(32'h10000 / ((val == 0) ? 32'd1 : 32'(val)));
         end
         CSR_PHASE_OFFSET: cfg_offset    = val;
         CSR_PHASE_CAP:    cfg_cap       = val;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] pre, input logic [7:0] att,
                                 input logic [7:0] per, input logic [7:0] off,
                                 input logic [7:0] cap);
      wait_drained();
      write_reg(CSR_PRE_DELAY, pre);
      write_reg(CSR_ATTACK_LEN, att);
      write_reg(CSR_PERIOD, per);
      write_reg(CSR_PHASE_OFFSET, off);
      write_reg(CSR_PHASE_CAP, cap);
   endtask

   // Mostly start-then-ticks runs with random content; the rest is noise
   task automatic queue_random(input int n);
      int count;
      int ticks;
      count = 0;
      while (count < n) begin
         if ($urandom_range(0, 99) < 85) begin
            push_word(OP_START, DELTA_W'($urandom));
            ticks = $urandom_range(1, 30);
            repeat (ticks) push_word(OP_TICK, pick_delta());
            count += ticks + 1;
            if ($urandom_range(0, 99) < 30) begin
               push_word(OP_STOP, DELTA_W'($urandom));
               count++;
            end
         end else begin
            push_word(OP_WIDTH_RAND(), DELTA_W'($urandom));
            count++;
         end
      end
   endtask

   function automatic logic [OP_W-1:0] OP_WIDTH_RAND();
      return OP_W'($urandom_range(0, 3));
   endfunction

   function automatic logic [7:0] rand_byte(input int lo);
      return 8'($urandom_range(lo, 255));
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      real amp;
      // sine table: round(256 * sin(2*pi*i/256)), rounding half away from zero
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         amp = 256.0 * $sin(TWO_PI * i / 256.0);
         sine_tab[i] = (amp >= 0.0) ? $rtoi(amp + 0.5) : -$rtoi(0.5 - amp);
      end
      lfo_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: short pre-delay and fade-in, walked tick by tick
      apply_settings(8'd2, 8'd4, 8'd16, 8'd0, 8'd0);
      push_word(OP_TICK, 16'hffff);    // tick while disabled
      push_word(OP_UNUSED, 16'h1234);  // ignored op
      push_word(OP_STOP, 16'h0000);
      push_word(OP_START, 16'hffff);
      push_word(OP_TICK, 16'h0100);    // one whole tick, still silent
      push_word(OP_TICK, 16'h0100);    // pre-delay ends here
      push_word(OP_TICK, 16'h0080);    // fade-in at zero whole ticks
      push_word(OP_TICK, 16'h0100);
      push_word(OP_TICK, 16'h0180);
      push_word(OP_TICK, 16'h0100);    // fade-in ends, level unscaled
      push_word(OP_UNUSED, 16'hffff);  // repeats the held level
      push_word(OP_TICK, 16'hffff);
      push_word(OP_TICK, 16'h0000);
      push_word(OP_STOP, 16'hffff);
      push_word(OP_UNUSED, 16'h0000);

      // Directed: period zero, no pre-delay, no fade-in, full offset and cap
      apply_settings(8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
      push_word(OP_START, 16'h0000);
      push_word(OP_TICK, 16'h0000);
      push_word(OP_TICK, 16'h0000);
      push_word(OP_TICK, 16'hffff);
      push_word(OP_STOP, 16'h0000);

      // Random phases over extreme and random settings
      apply_settings(8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
      queue_random(40);
      apply_settings(8'd255, 8'd0, 8'd1, 8'd255, 8'd255);
      queue_random(40);
      apply_settings(8'd0, 8'd0, 8'd1, 8'd0, 8'd10);
      idle_on = 1'b0;                  // a stretch with no idling at all
      queue_random(40);
      apply_settings(rand_byte(0), rand_byte(0), rand_byte(1), rand_byte(0), rand_byte(0));
      idle_on = 1'b1;
      queue_random(40);
      apply_settings(rand_byte(0), rand_byte(0), rand_byte(0), rand_byte(0), rand_byte(0));
      queue_random(40);
      apply_settings(rand_byte(0), rand_byte(0), rand_byte(1), rand_byte(0), 8'd0);
      queue_random(40);

      // Long sustain run with full-size deltas: push the phase product into bit 31
      apply_settings(8'd0, 8'd0, 8'd1, rand_byte(0), rand_byte(1));
      push_word(OP_START, DELTA_W'($urandom));
      repeat (145) push_word(OP_TICK, DELTA_W'($urandom_range(16'hff00, 16'hffff)));

      wait_drained();
      if (level_expect_q.size() != 0) begin
         report_mismatch($sformatf("%0d levels never arrived", level_expect_q.size()));
      end
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
